FILE: design/dmwbc_pkg.sv
`default_nettype none
package dmwbc_pkg;

   localparam int AddrWidth = 18;
   localparam int DataWidth = 32;

   // Access kinds carried by the mode field.
   localparam logic [1:0] ModeRead    = 2'd0;
   localparam logic [1:0] ModeWrite   = 2'd1;
   localparam logic [1:0] ModePreload = 2'd2;

   typedef struct packed {
      logic [1:0]           mode;
      logic [AddrWidth-1:0] address;
      logic [DataWidth-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] read_data;
      logic                 hit;
      logic                 wrote_back;
      logic [DataWidth-1:0] hit_count;
      logic [DataWidth-1:0] miss_count;
   } rsp_type;

endpackage
`default_nettype wire

FILE: design/dmwbc_ram.sv
`default_nettype none
module dmwbc_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: design/dmwbc_front.sv
`default_nettype none
module dmwbc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire dmwbc_pkg::req_type  req_word,
   output logic                     q_valid,
   output dmwbc_pkg::req_type       q_word,
   input  wire logic                q_pop
);
   import dmwbc_pkg::*;

   // Two-entry queue between the front and the back.
   req_type     slot_ff [2];
   req_type     slot_in [2];
   logic [1:0]  count_ff, count_in;
   logic        push;

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_word  = slot_ff[0];

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (q_pop && q_valid) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (push) begin
         slot_in[count_in[0]] = req_word;
         count_in             = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/dmwbc_back.sv
`default_nettype none
module dmwbc_back #(
   parameter int NumLines = 1024,
   parameter int MemWords = 65536
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire dmwbc_pkg::req_type q_word,
   output logic                    q_pop,
   output logic                    rsp_valid,
   output dmwbc_pkg::rsp_type      rsp_word
);
   import dmwbc_pkg::*;

   localparam int IdxW  = $clog2(NumLines);
   localparam int WordW = 4;
   localparam int TagW  = AddrWidth - 6 - IdxW;
   localparam int SlotW = IdxW + WordW;
   localparam int MemW  = $clog2(MemWords);
   localparam int BlkW  = AddrWidth - 6;
   localparam int MaW   = (MemW + 2 > AddrWidth) ? MemW + 2 : AddrWidth;
   localparam int MetaW = TagW + 2;

   typedef enum logic [6:0] {
      StIdle  = 7'b0000001,
      StLook  = 7'b0000010,
      StWback = 7'b0000100,
      StFill  = 7'b0001000,
      StDone  = 7'b0010000,
      StWait  = 7'b0100000,
      StClear = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   req_type               cur_ff, cur_in;
   logic [WordW:0]        step_ff, step_in;
   logic [IdxW-1:0]       clear_ff, clear_in;
   logic                  wb_ff, wb_in;
   logic [DataWidth-1:0]  hits_ff, hits_in, miss_ff, miss_in;
   logic                  hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [IdxW-1:0]  idx;
   logic [TagW-1:0]  tag;
   logic [WordW-1:0] word;
   logic [TagW-1:0]  old_tag;
   logic             old_valid, old_dirty;
   logic [BlkW-1:0]  vblk, tblk;

   // Line state entry: {valid, dirty, tag}.
   logic             meta_we;
   logic [IdxW-1:0]  meta_wa, meta_ra;
   logic [MetaW-1:0] meta_wd, meta_rd;
   logic             line_we;
   logic [SlotW-1:0] line_wa, line_ra;
   logic [DataWidth-1:0] line_wd, line_rd;
   logic             mem_we;
   logic [MemW-1:0]  mem_wa, mem_ra;
   logic [DataWidth-1:0] mem_wd, mem_rd;

   assign idx       = cur_ff.address[6 +: IdxW];
   assign tag       = cur_ff.address[AddrWidth-1 -: TagW];
   assign word      = cur_ff.address[5:2];
   assign old_tag   = meta_rd[TagW-1:0];
   assign old_dirty = meta_rd[TagW];
   assign old_valid = meta_rd[TagW+1];
   assign vblk      = {old_tag, idx};
   assign tblk      = {tag, idx};

   dmwbc_ram #(.Width(MetaW), .Depth(NumLines)) u_meta (
      .clock, .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(meta_wd),
      .rd_addr(meta_ra), .rd_data(meta_rd));
   dmwbc_ram #(.Width(DataWidth), .Depth(NumLines * 16)) u_lines (
      .clock, .wr_en(line_we), .wr_addr(line_wa), .wr_data(line_wd),
      .rd_addr(line_ra), .rd_data(line_rd));
   dmwbc_ram #(.Width(DataWidth), .Depth(MemWords)) u_mem (
      .clock, .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(mem_rd));

   // Sequencer: lookup, optional 16-word writeback, 16-word refill, access.
   always_comb begin
      logic [MaW-1:0] maddr;
      state_in     = state_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      clear_in     = clear_ff;
      wb_in        = wb_ff;
      hit_in       = hit_ff;
      hits_in      = hits_ff;
      miss_in      = miss_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      meta_we      = 1'b0;
      meta_wa      = idx;
      meta_wd      = {1'b1, 1'b0, tag};
      meta_ra      = idx;
      line_we      = 1'b0;
      line_wa      = {idx, word};
      line_wd      = cur_ff.write_data;
      line_ra      = {idx, word};
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = line_rd;
      mem_ra       = '0;
      maddr        = '0;
      case (state_ff)
         StClear: begin
            // Clears one line state entry per cycle after reset.
            meta_we  = 1'b1;
            meta_wa  = clear_ff;
            meta_wd  = '0;
            clear_in = clear_ff + 1'b1;
            if (clear_ff == IdxW'(NumLines - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            // The line state of the incoming word is read as it is taken.
            meta_ra = q_word.address[6 +: IdxW];
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_word;
               wb_in  = 1'b0;
               if (q_word.mode == ModeRead || q_word.mode == ModeWrite) begin
                  state_in = StLook;
               end else begin
                  // Preload goes straight to the backing store.
                  maddr  = MaW'(q_word.address);
                  mem_we = (q_word.mode == ModePreload);
                  mem_wa = maddr[2 +: MemW];
                  mem_wd = q_word.write_data;
                  rsp_in       = '0;
                  rsp_in.hit_count  = hits_ff;
                  rsp_in.miss_count = miss_ff;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         StLook: begin
            step_in = '0;
            hit_in  = old_valid && (old_tag == tag);
            if (old_valid && (old_tag == tag)) begin
               state_in = StDone;
            end else if (old_valid && old_dirty) begin
               wb_in    = 1'b1;
               line_ra  = {idx, 4'd0};
               state_in = StWback;
            end else begin
               state_in = StFill;
            end
         end
         StWback: begin
            // Line read data arrives in the cycle after its read address.
            line_ra = {idx, step_ff[WordW-1:0] + 4'd1};
            maddr   = MaW'({vblk, step_ff[WordW-1:0], 2'b00});
            mem_we  = 1'b1;
            mem_wa  = maddr[2 +: MemW];
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd15) begin
               step_in  = '0;
               state_in = StFill;
            end
         end
         StFill: begin
            // Memory read issued at step, written into the line at step-1.
            maddr   = MaW'({tblk, step_ff[WordW-1:0], 2'b00});
            mem_ra  = maddr[2 +: MemW];
            line_we = (step_ff != 5'd0);
            line_wa = {idx, step_ff[WordW-1:0] - 4'd1};
            line_wd = mem_rd;
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd16) begin
               meta_we  = 1'b1;
               meta_wd  = {1'b1, 1'b0, tag};
               state_in = StDone;
            end
         end
         StDone: begin
            if (hit_ff) begin
               hits_in = hits_ff + 1'b1;
            end else begin
               miss_in = miss_ff + 1'b1;
            end
            if (cur_ff.mode == ModeWrite) begin
               line_we       = 1'b1;
               meta_we       = 1'b1;
               meta_wd       = {1'b1, 1'b1, tag};
               rsp_in        = '0;
               rsp_in.hit        = hit_ff;
               rsp_in.wrote_back = wb_ff;
               rsp_in.hit_count  = hits_in;
               rsp_in.miss_count = miss_in;
               rsp_valid_in  = 1'b1;
               state_in      = StIdle;
            end else begin
               state_in = StWait;
            end
         end
         StWait: begin
            rsp_in.read_data  = line_rd;
            rsp_in.hit        = hit_ff;
            rsp_in.wrote_back = wb_ff;
            rsp_in.hit_count  = hits_ff;
            rsp_in.miss_count = miss_ff;
            rsp_valid_in = 1'b1;
            state_in     = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      step_ff <= step_in;
      wb_ff   <= wb_in;
      hit_ff  <= hit_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= StClear;
         clear_ff     <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         hits_ff      <= hits_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

FILE: design/direct_mapped_writeback_cache.sv
// Direct-mapped write-back cache with its own backing word store.
// Input: a word is accepted on a clock edge where start is high and busy
// is low. Each word is a read, a write, a backing word preload or a no-op.
// Output: every word yields exactly one result, shown for one cycle with
// rsp_valid high. The receiver cannot stall; results are never held back.
// A two-entry queue decouples the front from the sequencer, so busy rises
// only when both entries wait.
// A preload is answered from the idle state, a hit after the lookup and
// done states (a read also waits for its line word). A clean miss adds a
// 16-word refill walk; a dirty miss adds a further 16-word writeback walk.
// Both walks move one word per cycle. Items are served one at a time.
// Reset clears the counters and the queue at once, then the sequencer
// clears the valid and dirty marks of every line, one line per cycle;
// words accepted meanwhile wait in the queue. Cached words, tags and
// backing words are undefined until written.
`default_nettype none
module direct_mapped_writeback_cache #(
   parameter int NUM_LINES = 1024,
   parameter int MEM_WORDS = 65536
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire dmwbc_pkg::req_type req_word,
   output logic                    rsp_valid,
   output dmwbc_pkg::rsp_type      rsp_word
);
   import dmwbc_pkg::*;

   logic    q_valid, q_pop;
   req_type q_word;

   // Front: accepts and queues words.
   dmwbc_front u_front (
      .clock, .reset, .start, .busy, .req_word,
      .q_valid, .q_word, .q_pop);

   // Back: runs lookups, walks and accesses.
   dmwbc_back #(.NumLines(NUM_LINES), .MemWords(MEM_WORDS)) u_back (
      .clock, .reset, .q_valid, .q_word, .q_pop, .rsp_valid, .rsp_word);

endmodule
`default_nettype wire

FILE: design/dmwbc_checker.sv
`default_nettype none
module dmwbc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire dmwbc_pkg::rsp_type rsp_word
);
   import dmwbc_pkg::*;

   // Nothing comes out of a block just reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   // A hit never reports a writeback.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.hit |-> !rsp_word.wrote_back)
      else $error("hit with writeback");

   // Writeback marks only come with a miss.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.wrote_back |-> !rsp_word.hit)
      else $error("writeback on hit");

   // The queue is empty after reset, so busy is low.
   assert property (@(posedge clock) $past(reset) |-> !busy)
      else $error("busy after reset");

endmodule

bind direct_mapped_writeback_cache dmwbc_checker u_checker (
   .clock, .reset, .busy, .rsp_valid, .rsp_word);
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;
   import dmwbc_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_valid;
   rsp_type rsp_word;

   // Shadow copy of the cache and its backing store.
   logic [31:0] shadow_mem [int];
   logic [31:0] shadow_line_words [0:16383];
   logic [1:0]  shadow_tags [0:1023];
   logic        shadow_valid [0:1023];
   logic        shadow_dirty [0:1023];
   logic [31:0] shadow_hits;
   logic [31:0] shadow_misses;

   // Results still owed by the cache, oldest first.
   rsp_type pending_rsp [$];
   int      error_count;
   // Line indexes whose backing blocks are fully preloaded, for every tag.
   logic [9:0] pool_index [0:3];

   direct_mapped_writeback_cache DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word)
   );

   always #6 clock = ~clock;

   // Works out the result of one access and updates the shadow state.
   function automatic rsp_type predict_access(req_type w);
      rsp_type    r;
      logic [9:0] idx;
      logic [1:0] tag;
      logic [3:0] word;
      int         base;
      int         victim;
      int         target;
      r = '0;
      idx = w.address[15:6];
      tag = w.address[17:16];
      word = w.address[5:2];
      base = int'(idx) * 16;
      if (w.mode == ModeRead || w.mode == ModeWrite) begin
         if (shadow_valid[idx] && shadow_tags[idx] == tag) begin
            r.hit = 1'b1;
            shadow_hits = shadow_hits + 1;
         end else begin
            if (shadow_valid[idx] && shadow_dirty[idx]) begin
               victim = (int'(shadow_tags[idx]) * 1024 + int'(idx)) * 16;
               for (int i = 0; i < 16; i++) begin
                  shadow_mem[victim + i] = shadow_line_words[base + i];
               end
               r.wrote_back = 1'b1;
            end
            target = (int'(tag) * 1024 + int'(idx)) * 16;
            for (int i = 0; i < 16; i++) begin
               shadow_line_words[base + i] = shadow_mem[target + i];
            end
            shadow_tags[idx] = tag;
            shadow_valid[idx] = 1'b1;
            shadow_dirty[idx] = 1'b0;
            shadow_misses = shadow_misses + 1;
         end
         if (w.mode == ModeRead) begin
            r.read_data = shadow_line_words[base + int'(word)];
         end else begin
            shadow_line_words[base + int'(word)] = w.write_data;
            shadow_dirty[idx] = 1'b1;
         end
      end else if (w.mode == ModePreload) begin
         shadow_mem[int'(w.address[17:2])] = w.write_data;
      end
      r.hit_count = shadow_hits;
      r.miss_count = shadow_misses;
      return r;
   endfunction

   // Sends one word after a random gap and logs its expected result.
   task automatic send_word(logic [1:0] mode, logic [17:0] address, logic [31:0] data);
      int      gap;
      req_type w;
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.mode = mode;
      w.address = address;
      w.write_data = data;
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_access(w));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
   endtask

   function automatic logic [17:0] pool_address(int slot, logic [1:0] tag);
      return {tag, pool_index[slot], 6'($urandom)};
   endfunction

   // Preloads every word of every pool block under all four tags.
   task automatic test_preload_pool();
      logic [31:0] data;
      for (int s = 0; s < 4; s++) begin
         for (int t = 0; t < 4; t++) begin
            for (int wd = 0; wd < 16; wd++) begin
               data = $urandom;
               if (s == 0 && t == 0 && wd == 1) data = 32'h0;
               if (s == 1 && t == 3 && wd == 2) data = 32'hFFFF_FFFF;
               send_word(ModePreload, {t[1:0], pool_index[s], wd[3:0], 2'b00}, data);
            end
         end
      end
   endtask

   // Hits, misses, writebacks, conflict write miss, stale preload and mode 3.
   task automatic test_directed();
      send_word(ModeRead, 18'h00000, 32'h0);
      send_word(ModeRead, 18'h00004, 32'hFFFF_FFFF);
      send_word(ModeWrite, 18'h0003C, 32'hFFFF_FFFF);
      send_word(ModeRead, 18'h30000, 32'h0);
      send_word(ModeWrite, 18'h00008, 32'hA5A5_5A5A);
      send_word(ModeRead, 18'h0003C, 32'h0);
      send_word(ModeRead, 18'h3FFFF, 32'h0);
      send_word(ModeWrite, 18'h3FFFF, 32'h0);
      send_word(ModePreload, 18'h3FFFF, 32'h0001_2345);
      send_word(ModeRead, 18'h3FFFC, 32'h0);
      send_word(2'd3, 18'h3FFFF, 32'hFFFF_FFFF);
      send_word(ModeRead, 18'h0FFC0, 32'h0);
      send_word(ModeRead, 18'h3FFFC, 32'h0);
      send_word(ModeWrite, 18'h1FFC4, 32'h8000_0001);
      send_word(ModeWrite, 18'h2FFC4, 32'h7FFF_FFFE);
   endtask

   // Mostly cached accesses inside the pool, with preloads and mode 3 as noise.
   task automatic test_random(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (n == count / 2) drain_results();
         if (pick < 45) begin
            send_word(ModeRead, pool_address($urandom_range(0, 3), 2'($urandom)), $urandom);
         end else if (pick < 85) begin
            send_word(ModeWrite, pool_address($urandom_range(0, 3), 2'($urandom)), $urandom);
         end else if (pick < 95) begin
            send_word(ModePreload, 18'($urandom), $urandom);
         end else begin
            send_word(2'd3, 18'($urandom), $urandom);
         end
      end
   endtask

   task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
         error_count++;
      end
   endtask

   // Compares each result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_word);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("read_data", want.read_data, rsp_word.read_data);
            check_field("hit", 32'(want.hit), 32'(rsp_word.hit));
            check_field("wrote_back", 32'(want.wrote_back), 32'(rsp_word.wrote_back));
            check_field("hit_count", want.hit_count, rsp_word.hit_count);
            check_field("miss_count", want.miss_count, rsp_word.miss_count);
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      error_count = 0;
      shadow_hits = '0;
      shadow_misses = '0;
      for (int i = 0; i < 1024; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_dirty[i] = 1'b0;
      end
      pool_index[0] = 10'd0;
      pool_index[1] = 10'd1023;
      pool_index[2] = 10'($urandom);
      pool_index[3] = 10'($urandom);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_preload_pool();
      test_directed();
      test_random(880);
      drain_results();
      repeat (60) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
design/dmwbc_pkg.sv
design/dmwbc_ram.sv
design/dmwbc_front.sv
design/dmwbc_back.sv
design/direct_mapped_writeback_cache.sv
design/dmwbc_checker.sv
verif/tb.sv
